// ----- src/length_bucket_batcher_defines.svh -----
// Assertion macros used by the checker file.
`ifndef LENGTH_BUCKET_BATCHER_DEFINES_SVH
`define LENGTH_BUCKET_BATCHER_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define LBB_ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("%m: check failed");
// Implication whose consequent is checked in the next cycle.
`define LBB_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("%m: check failed");
`endif

// ----- src/lbb_pkg.sv -----
`default_nettype none
package lbb_pkg;
    localparam int NUM_BUCKETS_DEF = 4;
    localparam int MAX_BATCH_DEF   = 8;
    localparam int TAG_WIDTH_DEF   = 16;

    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_FLUSH = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [1:0] KIND_ELEM  = 2'd0;
    localparam logic [1:0] KIND_SHORT = 2'd1;
    localparam logic [1:0] KIND_LONG  = 2'd2;
    localparam logic [1:0] KIND_DONE  = 2'd3;

    localparam logic [2:0] REG_MIN   = 3'd0;
    localparam logic [2:0] REG_LIM0  = 3'd1;
    localparam logic [2:0] REG_LIM1  = 3'd2;
    localparam logic [2:0] REG_LIM2  = 3'd3;
    localparam logic [2:0] REG_LIM3  = 3'd4;
    localparam logic [2:0] REG_BATCH = 3'd5;
    localparam logic [2:0] REG_MODE  = 3'd6;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] item_tag;
        logic [15:0] item_length;
    } t_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] out_tag;
        logic [1:0]  bucket_index;
        logic        batch_last;
    } t_out;

    // Classified command handed from the front part to the back part.
    typedef struct packed {
        logic [1:0]  op;      // command code; for push, kind carries error kinds
        logic [1:0]  kind;    // KIND_ELEM means store, else report
        logic [2:0]  bucket;
        logic [15:0] tag;
    } t_work;
endpackage
`default_nettype wire

// ----- src/lbb_front.sv -----
`default_nettype none
module lbb_front
    import lbb_pkg::*;
#(
    parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
    parameter int TAG_WIDTH   = TAG_WIDTH_DEF
) (
    input  wire  logic        i_clk,
    input  wire  logic        i_rst_n,
    input  wire  t_in         i_item,
    input  wire  logic        i_take,
    input  wire  logic [15:0] i_min_length,
    input  wire  logic [63:0] i_limits,
    input  wire  logic [2:0]  i_mode,
    input  wire  logic        i_q_full,
    output logic              o_busy,
    output logic              o_q_push,
    output t_work             o_q_data
);
    // Tag bits kept; the tag field itself is 16 bits wide.
    localparam int TW = (TAG_WIDTH < 16) ? TAG_WIDTH : 16;

    // One registered stage: the item is classified in the cycle after it is taken.
    logic  r_vld;
    t_in   r_item;
    logic  [15:0] w_lim [NUM_BUCKETS];
    logic  [2:0]  w_bkt;
    logic  w_found;
    logic  [15:0] w_max;
    logic  [15:0] w_tag;

    always_comb begin
        for (int b = 0; b < NUM_BUCKETS; b++) begin
            w_lim[b] = i_limits[16*((b < 4) ? b : 3) +: 16];
        end
        w_max = w_lim[NUM_BUCKETS-1];
        w_bkt = '0;
        w_found = 1'b0;
        for (int b = 0; b < NUM_BUCKETS; b++) begin
            if (!w_found && r_item.item_length <= w_lim[b]) begin
                w_found = 1'b1;
                w_bkt = 3'(b);
            end
        end
        w_tag = 16'(r_item.item_tag[TW-1:0]);
    end

    always_comb begin
        o_q_data.op = r_item.cmd;
        o_q_data.kind = KIND_ELEM;
        o_q_data.bucket = w_bkt;
        o_q_data.tag = w_tag;
        o_q_push = 1'b0;
        case (r_item.cmd)
            CMD_PUSH: begin
                if (r_item.item_length < i_min_length) begin
                    o_q_data.kind = KIND_SHORT;
                    o_q_push = r_vld && !i_mode[0];
                end else if (r_item.item_length > w_max) begin
                    o_q_data.kind = KIND_LONG;
                    o_q_push = r_vld && !i_mode[1];
                end else begin
                    o_q_push = r_vld;
                end
            end
            CMD_FLUSH, CMD_CLEAR: o_q_push = r_vld;
            default: o_q_push = 1'b0;
        endcase
    end

    assign o_busy = r_vld && o_q_push && i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (!o_busy) begin
            r_vld <= i_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_busy && i_take) begin
            r_item <= i_item;
        end
    end
endmodule
`default_nettype wire

// ----- src/lbb_fifo.sv -----
`default_nettype none
module lbb_fifo
    import lbb_pkg::*;
(
    input  wire  logic  i_clk,
    input  wire  logic  i_rst_n,
    input  wire  logic  i_push,
    input  wire  t_work i_data,
    output logic        o_full,
    input  wire  logic  i_pop,
    output logic        o_empty,
    output t_work       o_data
);
    // Two-entry queue between front and back.
    t_work r_mem [2];
    logic  r_wp, r_rp;
    logic  [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) r_wp <= ~r_wp;
            if (i_pop && !o_empty) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push && !o_full) - 2'(i_pop && !o_empty);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) r_mem[r_wp] <= i_data;
    end
endmodule
`default_nettype wire

// ----- src/lbb_back.sv -----
`default_nettype none
module lbb_back
    import lbb_pkg::*;
#(
    parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
    parameter int MAX_BATCH   = MAX_BATCH_DEF
) (
    input  wire  logic        i_clk,
    input  wire  logic        i_rst_n,
    input  wire  logic        i_q_empty,
    input  wire  t_work       i_q_data,
    output logic              o_q_pop,
    input  wire  logic [15:0] i_batch_sizes,
    input  wire  logic [2:0]  i_mode,
    output logic              o_empty,
    output t_out              o_result,
    input  wire  logic        i_pop
);
    localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int FW = $clog2(MAX_BATCH + 1);
    localparam int DEPTH = NUM_BUCKETS * MAX_BATCH;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EMIT  = 3'd1;  // push-triggered batch
    localparam logic [2:0] ST_FSEL  = 3'd2;  // flush: evaluate bucket r_cur
    localparam logic [2:0] ST_FOWN  = 3'd3;  // flush: emit own slots
    localparam logic [2:0] ST_FTOP  = 3'd4;  // flush: top-up from lower buckets
    localparam logic [2:0] ST_DONE  = 3'd5;
    localparam logic [2:0] ST_FRD   = 3'd6;  // flush: read of top-up slot pending

    logic [2:0]    r_st;
    logic [15:0]   r_mem [DEPTH];
    logic [FW-1:0] r_fill [NUM_BUCKETS];
    logic [BW-1:0] r_cur, r_src;
    logic [FW-1:0] r_s, r_cnt, r_own, r_take;
    logic [AW-1:0] r_rd_addr;
    logic [15:0]   r_rd;
    logic          r_rd_vld;
    // Output register, one entry.
    logic          r_ovld;
    t_out          r_out;

    logic          w_ofree;
    assign w_ofree = !r_ovld || i_pop;
    assign o_empty = !r_ovld;
    assign o_result = r_out;

    function automatic logic [FW-1:0] batch_of(input logic [15:0] sizes,
                                               input int b);
        logic [3:0] n;
        n = sizes[4*((b < 4) ? b : 3) +: 4];
        if (n == 4'd0) n = 4'd1;
        if (32'(n) > MAX_BATCH) return FW'(MAX_BATCH);
        return FW'(n);
    endfunction

    function automatic logic [AW-1:0] addr(input logic [BW-1:0] b,
                                           input logic [FW-1:0] s);
        return AW'(b) * AW'(MAX_BATCH) + AW'(s);
    endfunction

    // Lower-bucket sum and top-up count for the flush bucket; batch size and fill for the queued push.
    logic [LW-1:0] w_lower;
    logic [FW-1:0] w_size, w_rem, w_take, w_bsz, w_f;
    always_comb begin
        w_lower = '0;
        for (int j = 0; j < NUM_BUCKETS; j++) begin
            if (j < 32'(r_cur)) w_lower = w_lower + LW'(r_fill[j]);
        end
        w_size = '0;
        w_bsz = '0;
        for (int b = 0; b < NUM_BUCKETS; b++) begin
            if (32'(r_cur) == b) w_size = batch_of(i_batch_sizes, b);
            if (32'(i_q_data.bucket) == b) w_bsz = batch_of(i_batch_sizes, b);
        end
        w_rem = (w_size > r_fill[r_cur]) ? w_size - r_fill[r_cur] : '0;
        w_take = (LW'(w_rem) < w_lower) ? w_rem : FW'(w_lower);
        w_f = r_fill[i_q_data.bucket[BW-1:0]];
        if (w_f >= FW'(MAX_BATCH)) w_f = FW'(MAX_BATCH - 1);
    end

    assign o_q_pop = (r_st == ST_IDLE) && !i_q_empty && w_ofree;

    logic [BW-1:0] w_nsrc;
    always_comb begin
        w_nsrc = r_src;
        // Find the highest nonempty lower bucket at or below r_src.
        for (int j = 0; j < NUM_BUCKETS; j++) begin
            if (j <= 32'(r_src) && r_fill[j] != '0) begin
                w_nsrc = BW'(j);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_ovld <= 1'b0;
            r_rd_vld <= 1'b0;
            for (int b = 0; b < NUM_BUCKETS; b++) r_fill[b] <= '0;
        end else begin
            if (i_pop) r_ovld <= 1'b0;
            r_rd_vld <= 1'b0;
            case (r_st)
                ST_IDLE: begin
                    if (o_q_pop) begin
                        case (i_q_data.op)
                            CMD_PUSH: begin
                                if (i_q_data.kind != KIND_ELEM) begin
                                    r_ovld <= 1'b1;
                                    r_out <= '{kind: i_q_data.kind,
                                               out_tag: i_q_data.tag,
                                               bucket_index: 2'd0,
                                               batch_last: 1'b0};
                                end else begin
                                    r_mem[addr(i_q_data.bucket[BW-1:0], w_f)] <=
                                        i_q_data.tag;
                                    if (w_f + 1'b1 >= w_bsz) begin
                                        r_fill[i_q_data.bucket[BW-1:0]] <= '0;
                                        r_cur <= i_q_data.bucket[BW-1:0];
                                        r_cnt <= w_f + 1'b1;
                                        r_s <= '0;
                                        r_rd_addr <= addr(i_q_data.bucket[BW-1:0], '0);
                                        r_st <= ST_EMIT;
                                    end else begin
                                        r_fill[i_q_data.bucket[BW-1:0]] <= w_f + 1'b1;
                                    end
                                end
                            end
                            CMD_FLUSH: begin
                                r_cur <= BW'(NUM_BUCKETS - 1);
                                r_st <= ST_FSEL;
                            end
                            CMD_CLEAR: begin
                                for (int b = 0; b < NUM_BUCKETS; b++) r_fill[b] <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_EMIT, ST_FOWN: begin
                    // Memory read is registered; each tag is read, then sent once the output is free.
                    if (!r_rd_vld) begin
                        r_rd <= r_mem[r_rd_addr];
                        r_rd_vld <= 1'b1;
                    end
                    if (r_rd_vld && w_ofree) begin
                        r_ovld <= 1'b1;
                        r_out <= '{kind: KIND_ELEM, out_tag: r_rd,
                                   bucket_index: 2'(r_cur),
                                   batch_last: (r_s + 1'b1 == r_cnt)};
                        r_s <= r_s + 1'b1;
                        r_rd_addr <= r_rd_addr + 1'b1;
                        if (r_st == ST_EMIT) begin
                            if (r_s + 1'b1 == r_cnt) r_st <= ST_IDLE;
                        end else if (r_s + 1'b1 == r_own) begin
                            r_st <= (r_take != '0) ? ST_FTOP : ST_FSEL;
                            if (r_take == '0) begin
                                r_fill[r_cur] <= '0;
                                if (r_cur == '0) r_st <= ST_DONE;
                                else r_cur <= r_cur - 1'b1;
                            end
                            r_src <= r_cur - 1'b1;
                        end
                    end else if (r_rd_vld) begin
                        r_rd_vld <= 1'b1;
                    end
                end
                ST_FSEL: begin
                    if (r_fill[r_cur] == '0) begin
                        if (r_cur == '0) r_st <= ST_DONE;
                        else r_cur <= r_cur - 1'b1;
                    end else if (i_mode[2] && (r_fill[r_cur] + w_take) < w_size) begin
                        for (int j = 0; j < NUM_BUCKETS; j++) begin
                            if (j <= 32'(r_cur)) r_fill[j] <= '0;
                        end
                        r_st <= ST_DONE;
                    end else begin
                        r_own <= r_fill[r_cur];
                        r_take <= w_take;
                        r_cnt <= r_fill[r_cur] + w_take;
                        r_s <= '0;
                        r_rd_addr <= addr(r_cur, '0);
                        r_st <= ST_FOWN;
                    end
                end
                ST_FTOP: begin
                    // Pop one tag from the back of the highest nonempty lower bucket.
                    r_src <= w_nsrc;
                    r_fill[w_nsrc] <= r_fill[w_nsrc] - 1'b1;
                    r_rd <= r_mem[addr(w_nsrc, r_fill[w_nsrc] - 1'b1)];
                    r_take <= r_take - 1'b1;
                    r_st <= ST_FRD;
                end
                ST_FRD: begin
                    if (w_ofree) begin
                        r_ovld <= 1'b1;
                        r_out <= '{kind: KIND_ELEM, out_tag: r_rd,
                                   bucket_index: 2'(r_cur),
                                   batch_last: (r_s + 1'b1 == r_cnt)};
                        r_s <= r_s + 1'b1;
                        if (r_take != '0) begin
                            r_st <= ST_FTOP;
                        end else begin
                            r_fill[r_cur] <= '0;
                            if (r_cur == '0) r_st <= ST_DONE;
                            else begin
                                r_cur <= r_cur - 1'b1;
                                r_st <= ST_FSEL;
                            end
                        end
                    end
                end
                ST_DONE: begin
                    if (w_ofree) begin
                        r_ovld <= 1'b1;
                        r_out <= '{kind: KIND_DONE, out_tag: 16'd0,
                                   bucket_index: 2'd0, batch_last: 1'b0};
                        r_st <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- src/length_bucket_batcher.sv -----
// Length-bucketed batcher.
// Input channel: a command transaction (push item, flush, clear) is taken when
// i_push is high and o_full is low. Result channel: the oldest result sits on
// o_result while o_empty is low and leaves when i_pop is high.
// Configuration: a write transaction on i_cfg_valid/o_cfg_ready sets one of the
// seven registers; the user makes writes only while the block is idle, which the
// block does not enforce. A command is classified in the cycle after it is
// taken and enters a two-entry queue at the end of that cycle if the queue has
// room; the idle back end takes it once its output register is free and writes
// an error report straight into that register. Pushes that complete no batch
// go one per cycle while the output register is free. A completed batch leaves
// element by element, each through a registered read of the tag memory, and the
// back end takes no command until it is out. At flush each bucket is examined
// in turn, own and top-up elements leave, and a done result follows.
// Reset empties all buckets and restores register defaults; the tag memory is
// not cleared, since only held slots are ever read.
// When the receiver stalls, the single output register holds its result, the
// back end waits, the queue fills and o_full rises; nothing is lost.
`default_nettype none
module length_bucket_batcher
    import lbb_pkg::*;
#(
    parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
    parameter int MAX_BATCH   = MAX_BATCH_DEF,
    parameter int TAG_WIDTH   = TAG_WIDTH_DEF
) (
    input  wire  logic        i_clk,
    input  wire  logic        i_rst_n,
    input  wire  logic        i_push,
    output logic              o_full,
    input  wire  t_in         i_item,
    output logic              o_empty,
    input  wire  logic        i_pop,
    output t_out              o_result,
    input  wire  logic        i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire  logic [2:0]  i_cfg_index,
    input  wire  logic [15:0] i_cfg_data
);
    logic [15:0] r_min_length, r_batch_sizes;
    logic [63:0] r_limits;
    logic [2:0]  r_mode;

    logic  w_busy, w_qpush, w_qfull, w_qpop, w_qempty;
    t_work w_qin, w_qout;

    // The front stage holds one command; it refuses the next one while stuck.
    assign o_full = w_busy;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_length <= 16'd0;
            r_limits <= {16'd512, 16'd256, 16'd128, 16'd64};
            r_batch_sizes <= 16'h8888;
            r_mode <= 3'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_MIN:   r_min_length <= i_cfg_data;
                REG_LIM0:  r_limits[15:0] <= i_cfg_data;
                REG_LIM1:  r_limits[31:16] <= i_cfg_data;
                REG_LIM2:  r_limits[47:32] <= i_cfg_data;
                REG_LIM3:  r_limits[63:48] <= i_cfg_data;
                REG_BATCH: r_batch_sizes <= i_cfg_data;
                REG_MODE:  r_mode <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    lbb_front #(.NUM_BUCKETS(NUM_BUCKETS), .TAG_WIDTH(TAG_WIDTH)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(i_item),
        .i_take(i_push && !w_busy), .i_min_length(r_min_length),
        .i_limits(r_limits), .i_mode(r_mode), .i_q_full(w_qfull),
        .o_busy(w_busy), .o_q_push(w_qpush), .o_q_data(w_qin)
    );

    lbb_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_qpush), .i_data(w_qin),
        .o_full(w_qfull), .i_pop(w_qpop), .o_empty(w_qempty), .o_data(w_qout)
    );

    lbb_back #(.NUM_BUCKETS(NUM_BUCKETS), .MAX_BATCH(MAX_BATCH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_empty(w_qempty), .i_q_data(w_qout),
        .o_q_pop(w_qpop), .i_batch_sizes(r_batch_sizes), .i_mode(r_mode),
        .o_empty(o_empty), .o_result(o_result), .i_pop(i_pop)
    );
endmodule
`default_nettype wire

// ----- src/length_bucket_batcher_checker.sv -----
`include "length_bucket_batcher_defines.svh"
`default_nettype none
module length_bucket_batcher_checker
    import lbb_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_pop,
    input wire logic o_empty,
    input wire t_out o_result
);
    // A waiting result holds while not taken.
    `LBB_ASSERT_NEXT(a_hold, i_clk, i_rst_n, !o_empty && !i_pop, $stable(o_result))
    `LBB_ASSERT_NEXT(a_stay, i_clk, i_rst_n, !o_empty && !i_pop, !o_empty)
    // Reports and done carry no batch flag.
    `LBB_ASSERT_IMPL(a_last, i_clk, i_rst_n, !o_empty && o_result.kind != KIND_ELEM,
        !o_result.batch_last && o_result.bucket_index == 2'd0)
    `LBB_ASSERT_IMPL(a_done, i_clk, i_rst_n, !o_empty && o_result.kind == KIND_DONE,
        o_result.out_tag == 16'd0)
endmodule
bind length_bucket_batcher length_bucket_batcher_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_pop(i_pop), .o_empty(o_empty),
    .o_result(o_result)
);
`default_nettype wire

// ----- test/length_bucket_batcher_tb.sv -----
`timescale 1ns / 1ps
`default_nettype none

module length_bucket_batcher_tb;
    import lbb_pkg::*;

    // Scoreboard that models the bucket state and keeps the queue of expected results.
    class batch_scoreboard;
        logic [15:0] min_len;
        logic [15:0] limit [4];
        logic [15:0] sizes;
        logic [2:0]  mode;
        logic [15:0] store [4][8];
        int unsigned fill [4];
        t_out        pending [$];
        int          errors;

        function void reset_state();
            min_len = 16'd0;
            limit[0] = 16'd64;
            limit[1] = 16'd128;
            limit[2] = 16'd256;
            limit[3] = 16'd512;
            sizes = 16'h8888;
            mode = 3'd0;
            foreach (fill[b]) fill[b] = 0;
            pending.delete();
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] val);
            case (idx)
                REG_MIN:   min_len = val;
                REG_LIM0:  limit[0] = val;
                REG_LIM1:  limit[1] = val;
                REG_LIM2:  limit[2] = val;
                REG_LIM3:  limit[3] = val;
                REG_BATCH: sizes = val;
                REG_MODE:  mode = val[2:0];
                default: ;
            endcase
        endfunction

        function int unsigned size_of(int b);
            int unsigned n;
            n = (sizes >> (4 * b)) & 4'hF;
            if (n == 0) n = 1;
            if (n > 8) n = 8;
            return n;
        endfunction

        function void add(logic [1:0] kind, logic [15:0] tag, int b, bit last);
            t_out r;
            r.kind = kind;
            r.out_tag = tag;
            r.bucket_index = b[1:0];
            r.batch_last = last;
            pending.insert(pending.size(), r);
        endfunction

        function void push_item(logic [15:0] tag, logic [15:0] len);
            int unsigned f;
            if (len < min_len) begin
                if (!mode[0]) add(KIND_SHORT, tag, 0, 1'b0);
                return;
            end
            if (len > limit[3]) begin
                if (!mode[1]) add(KIND_LONG, tag, 0, 1'b0);
                return;
            end
            for (int b = 0; b < 4; b++) begin
                if (len <= limit[b]) begin
                    f = fill[b];
                    if (f >= 8) f = 7;
                    store[b][f] = tag;
                    f++;
                    fill[b] = f;
                    if (f >= size_of(b)) begin
                        for (int s = 0; s < f; s++) add(KIND_ELEM, store[b][s], b, s + 1 == f);
                        fill[b] = 0;
                    end
                    return;
                end
            end
        endfunction

        function void flush_all();
            int unsigned own, sz, rem, lower, take, count, s;
            for (int i = 3; i >= 0; i--) begin
                own = fill[i];
                if (own == 0) continue;
                sz = size_of(i);
                rem = (sz > own) ? sz - own : 0;
                lower = 0;
                for (int j = 0; j < i; j++) lower += fill[j];
                take = (rem < lower) ? rem : lower;
                count = own + take;
                if (mode[2] && count < sz) begin
                    for (int j = 0; j <= i; j++) fill[j] = 0;
                    break;
                end
                for (s = 0; s < own; s++) add(KIND_ELEM, store[i][s], i, s + 1 == count);
                // Top-up takes from the backs of the lower buckets, nearest one first.
                for (int j = i; j > 0 && take > 0; j--) begin
                    while (take > 0 && fill[j-1] > 0) begin
                        fill[j-1]--;
                        take--;
                        s++;
                        add(KIND_ELEM, store[j-1][fill[j-1]], i, s == count);
                    end
                end
                fill[i] = 0;
            end
            add(KIND_DONE, 16'd0, 0, 1'b0);
        endfunction

        // Notes one accepted command transaction.
        function void note_item(t_in it);
            case (it.cmd)
                CMD_PUSH:  push_item(it.item_tag, it.item_length);
                CMD_FLUSH: flush_all();
                CMD_CLEAR: foreach (fill[b]) fill[b] = 0;
                default: ;
            endcase
        endfunction

        task report_mismatch(string what, t_out want, t_out got);
            errors++;
            $display("MISMATCH %s: expected %h got %h at %0t", what, want, got, $realtime);
        endtask

        // Checks one accepted result transaction against the oldest expectation.
        task check_result(t_out got);
            t_out want;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result", 0, got);
                return;
            end
            want = pending.pop_front();
            if (got.kind !== want.kind) report_mismatch("kind", want, got);
            else if (got.out_tag !== want.out_tag) report_mismatch("out_tag", want, got);
            else if (got.bucket_index !== want.bucket_index)
                report_mismatch("bucket_index", want, got);
            else if (got.batch_last !== want.batch_last)
                report_mismatch("batch_last", want, got);
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        push;
    logic        full;
    t_in         item;
    logic        empty;
    logic        pop = 1'b0;
    t_out        result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    batch_scoreboard sb;
    int          idle_pct;
    int          quiet_cycles = 0;
    bit          timed_out = 1'b0;

    length_bucket_batcher u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_item      (item),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (result),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // The receiver pops at random; the result is sampled on the same edge where
    // the DUT still holds it, and the model is compared right there.
    always @(posedge clk) begin
        if (rst_n && pop && !empty) sb.check_result(result);
        if (rst_n && (pop && !empty || push && !full || cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        pop <= ($urandom_range(99) >= idle_pct);
    end

    // A long stall count with nothing moving means the block has hung.
    always @(posedge clk) begin
        if (quiet_cycles > 5000 && !timed_out) begin
            timed_out = 1'b1;
            $display("length_bucket_batcher test failed");
            $finish;
        end
    end

    // Sends one command transaction, with an optional random gap before it.
    // The push line stays high after acceptance until the next gap or drain.
    task automatic send_item(logic [1:0] cmd, logic [15:0] tag, logic [15:0] len);
        while ($urandom_range(99) < idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        item <= '{cmd: cmd, item_tag: tag, item_length: len};
        push <= 1'b1;
        do @(posedge clk); while (full);
        sb.note_item('{cmd: cmd, item_tag: tag, item_length: len});
    endtask

    task automatic write_cfg(logic [2:0] idx, logic [15:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Waits until every expected result has come, then lets the pipeline settle
    // so that dropped or silent commands have left the block too.
    task automatic drain();
        push <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_all(logic [15:0] mn, logic [15:0] l0, logic [15:0] l1,
                           logic [15:0] l2, logic [15:0] l3, logic [15:0] bs,
                           logic [2:0] md);
        drain();
        write_cfg(REG_MIN, mn);
        write_cfg(REG_LIM0, l0);
        write_cfg(REG_LIM1, l1);
        write_cfg(REG_LIM2, l2);
        write_cfg(REG_LIM3, l3);
        write_cfg(REG_BATCH, bs);
        write_cfg(REG_MODE, md);
    endtask

    // Mostly valid pushes with lengths around the bucket limits, some errors,
    // flushes now and then, and a rare clear or unused command.
    task automatic random_phase(int count);
        int pick;
        logic [15:0] len;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            case ($urandom_range(5))
                0: len = sb.limit[$urandom_range(3)];
                1: len = sb.limit[$urandom_range(3)] + 16'd1;
                2: len = sb.min_len - 16'd1;
                3: len = 16'($urandom);
                default: len = 16'($urandom_range(sb.limit[3]));
            endcase
            if (pick < 82) send_item(CMD_PUSH, 16'($urandom), len);
            else if (pick < 92) send_item(CMD_FLUSH, 16'($urandom), 16'($urandom));
            else if (pick < 97) send_item(CMD_CLEAR, 16'($urandom), 16'($urandom));
            else send_item(2'd3, 16'($urandom), 16'($urandom));
        end
        send_item(CMD_FLUSH, 16'd0, 16'd0);
    endtask

    initial begin
        sb = new();
        sb.reset_state();
        rst_n = 1'b0;
        push = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_MIN;
        cfg_data = 16'd0;
        idle_pct = 14;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: defaults, the field extremes, the long error kind and empty flush.
        send_item(CMD_FLUSH, 16'hFFFF, 16'hFFFF);
        send_item(CMD_PUSH, 16'h0000, 16'd0);
        send_item(CMD_PUSH, 16'hFFFF, 16'd64);
        send_item(CMD_PUSH, 16'hA5A5, 16'd65);
        send_item(CMD_PUSH, 16'h5A5A, 16'd512);
        send_item(CMD_PUSH, 16'h1234, 16'd513);
        send_item(CMD_PUSH, 16'h4321, 16'hFFFF);
        send_item(CMD_FLUSH, 16'd0, 16'd0);
        send_item(2'd3, 16'hFFFF, 16'hFFFF);
        // Short items reported, batch size of zero and one above the maximum.
        set_all(16'd10, 16'd20, 16'd40, 16'd60, 16'hFFFF, 16'h9F01, 3'd0);
        send_item(CMD_PUSH, 16'h0001, 16'd9);
        send_item(CMD_PUSH, 16'h0002, 16'd10);
        send_item(CMD_PUSH, 16'h0003, 16'hFFFF);
        send_item(CMD_PUSH, 16'h0004, 16'd30);
        send_item(CMD_CLEAR, 16'd0, 16'd0);
        send_item(CMD_FLUSH, 16'd0, 16'd0);
        // Batch size lowered below the fill count of a bucket.
        set_all(16'd0, 16'd64, 16'd128, 16'd256, 16'd512, 16'h8888, 3'd0);
        for (int k = 0; k < 5; k++) send_item(CMD_PUSH, 16'(16'h0100 + k), 16'd100);
        drain();
        write_cfg(REG_BATCH, 16'h8828);
        send_item(CMD_FLUSH, 16'd0, 16'd0);
        for (int k = 0; k < 5; k++) send_item(CMD_PUSH, 16'(16'h0200 + k), 16'd100);
        drain();
        write_cfg(REG_BATCH, 16'h8838);
        send_item(CMD_PUSH, 16'h0300, 16'd100);

        // Random phases over several settings, with a stretch without gaps.
        set_all(16'd0, 16'd64, 16'd128, 16'd256, 16'd512, 16'h8888, 3'd0);
        random_phase(30);
        set_all(16'd8, 16'd300, 16'd100, 16'd200, 16'd400, 16'h3524, 3'd7);
        random_phase(35);
        idle_pct = 0;
        set_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'h0000, 3'd1);
        random_phase(25);
        set_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd2);
        random_phase(17);
        idle_pct = 14;
        set_all(16'd5, 16'd50, 16'd150, 16'd600, 16'd1000, 16'h4683, 3'd4);
        random_phase(40);
        set_all(16'd1, 16'd10, 16'd20, 16'd30, 16'd40, 16'h2222, 3'd3);
        random_phase(40);

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("length_bucket_batcher test passed");
        end else begin
            $display("length_bucket_batcher test failed");
        end
        $finish;
    end
endmodule

`default_nettype wire
